// ===== rtl/sao_bef_pkg.sv =====
`timescale 1ns / 1ps

package sao_bef_pkg;

   localparam int PIXEL_BITS_DEF   = 10;
   localparam int MAX_WIDTH_DEF    = 128;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 10;
   localparam int OFFSET_BITS      = 10;
   localparam int BLOCK_WIDTH_BITS = 8;
   localparam int BAND_BITS        = 5;
   localparam int BAND_SPAN        = 4;
   localparam int BLOCK_WIDTH_RST  = 64;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FILTER_MODE,
      CSR_EDGE_CLASS,
      CSR_BAND_POSITION,
      CSR_OFFSET_ONE,
      CSR_OFFSET_TWO,
      CSR_OFFSET_THREE,
      CSR_OFFSET_FOUR,
      CSR_BLOCK_WIDTH
   } csr_index_type;

   typedef enum logic {
      MODE_BAND,
      MODE_EDGE
   } mode_type;

   typedef enum logic [1:0] {
      EDGE_HORIZONTAL,
      EDGE_VERTICAL,
      EDGE_DIAG_45,
      EDGE_DIAG_135
   } edge_class_type;

   typedef enum logic [2:0] {
      OFS_NONE,
      OFS_ONE,
      OFS_TWO,
      OFS_THREE,
      OFS_FOUR
   } offset_sel_type;

   // map edge index (2 + sign sum) to its offset: minimum, concave, flat, convex, maximum
   function automatic offset_sel_type category_pick(input logic [2:0] idx);
      offset_sel_type sel;
      case (idx)
         3'd0:    sel = OFS_ONE;
         3'd1:    sel = OFS_TWO;
         3'd3:    sel = OFS_THREE;
         3'd4:    sel = OFS_FOUR;
         default: sel = OFS_NONE;
      endcase
      return sel;
   endfunction

endpackage

// ===== rtl/sao_bef_req_if.sv =====
`timescale 1ns / 1ps

interface sao_bef_req_if import sao_bef_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] sample;
   logic                  last_of_block;

   modport source (output valid, output sample, output last_of_block, input ready);
   modport sink   (input valid, input sample, input last_of_block, output ready);
endinterface

// ===== rtl/sao_bef_rsp_if.sv =====
`timescale 1ns / 1ps

interface sao_bef_rsp_if import sao_bef_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] filtered;
   logic                  end_of_block;

   modport source (output valid, output filtered, output end_of_block, input ready);
   modport sink   (input valid, input filtered, input end_of_block, output ready);
endinterface

// ===== rtl/sao_bef_line_store.sv =====
`timescale 1ns / 1ps

// Both line stores in one word: {upper, middle}. Registered read; a write to the
// entry being read on the same edge is forwarded to the read data.
module sao_bef_line_store #(
   parameter int DATA_BITS = 20,
   parameter int DEPTH     = 130,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] q_ff;
   logic [DATA_BITS-1:0] byp_data_ff;
   logic                 byp_hit_ff;
   logic                 byp_hit_in;

   assign byp_hit_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else if (rd_en) begin
         byp_hit_ff <= byp_hit_in;
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : q_ff;

endmodule

// ===== rtl/sao_band_edge_filter.sv =====
`timescale 1ns / 1ps
// Path: an accepted request is held in stage 1, then registered into the response.
// Throughput: one transaction per cycle in both modes unless stalled, set by the
//   single line store read and write back per pixel; a stalled response holds one more.
// Reset: synchronous, clears the handshake state, counters and registers
//   (block_width to 64); line store contents stay undefined until written.
module sao_band_edge_filter import sao_bef_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   sao_bef_req_if.sink               req_chan,
   sao_bef_rsp_if.source             rsp_chan
);

   localparam int DEPTH     = MAX_WIDTH + 2;
   localparam int COL_BITS  = $clog2(DEPTH);
   localparam int WB        = (BLOCK_WIDTH_BITS > COL_BITS) ? BLOCK_WIDTH_BITS : COL_BITS;
   localparam int SUM_BITS  = ((PIXEL_BITS > OFFSET_BITS) ? PIXEL_BITS : OFFSET_BITS) + 2;
   localparam int PIXEL_MAX = (1 << PIXEL_BITS) - 1;

   // ---------------------------------------------------------------- registers
   mode_type                       mode_ff;
   edge_class_type                 edge_class_ff;
   logic [BAND_BITS-1:0]           band_pos_ff;
   logic signed [OFFSET_BITS-1:0]  offset_ff [BAND_SPAN];
   logic [BLOCK_WIDTH_BITS-1:0]    block_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_BAND;
         edge_class_ff  <= EDGE_HORIZONTAL;
         band_pos_ff    <= '0;
         for (int i = 0; i < BAND_SPAN; i++) begin
            offset_ff[i] <= '0;
         end
         block_width_ff <= BLOCK_WIDTH_BITS'(BLOCK_WIDTH_RST);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FILTER_MODE:   mode_ff        <= mode_type'(csr_wr_data[0]);
            CSR_EDGE_CLASS:    edge_class_ff  <= edge_class_type'(csr_wr_data[1:0]);
            CSR_BAND_POSITION: band_pos_ff    <= csr_wr_data[BAND_BITS-1:0];
            CSR_OFFSET_ONE:    offset_ff[0]   <= $signed(csr_wr_data[OFFSET_BITS-1:0]);
            CSR_OFFSET_TWO:    offset_ff[1]   <= $signed(csr_wr_data[OFFSET_BITS-1:0]);
            CSR_OFFSET_THREE:  offset_ff[2]   <= $signed(csr_wr_data[OFFSET_BITS-1:0]);
            CSR_OFFSET_FOUR:   offset_ff[3]   <= $signed(csr_wr_data[OFFSET_BITS-1:0]);
            CSR_BLOCK_WIDTH:   block_width_ff <= csr_wr_data[BLOCK_WIDTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   logic s1_valid_ff, s1_produce_ff, s1_last_ff;
   logic [PIXEL_BITS-1:0] s1_sample_ff;
   logic [COL_BITS-1:0]   s1_addr_ff;
   logic rsp_valid_ff;
   logic s1_adv, req_accept;

   // stage 1 moves on unless its result has nowhere to go
   assign s1_adv     = s1_valid_ff && (!s1_produce_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_accept = req_chan.valid && req_chan.ready;

   // ---------------------------------------------------------------- stage 0: counters
   logic [WB-1:0]       bw_ext;
   logic [COL_BITS-1:0] width_eff, col_ff, col_cur;
   logic [COL_BITS:0]   col_inc;
   logic                col_wrap, edge_produce;
   logic [1:0]          rows_ff;
   logic [COL_BITS-1:0] col_in;
   logic [1:0]          rows_in;

   // clamp width into 1 .. MAX_WIDTH
   assign bw_ext    = WB'(block_width_ff);
   assign width_eff = (bw_ext == '0)            ? COL_BITS'(1) :
                      (bw_ext > WB'(MAX_WIDTH)) ? COL_BITS'(MAX_WIDTH) :
                                                  COL_BITS'(bw_ext);

   // a column past the end of a narrowed row restarts the row
   assign col_cur  = (col_ff > width_eff + COL_BITS'(1)) ? '0 : col_ff;
   assign col_inc  = {1'b0, col_cur} + (COL_BITS+1)'(1);
   assign col_wrap = col_inc >= ({1'b0, width_eff} + (COL_BITS+1)'(2));
   assign edge_produce = (rows_ff == 2'd2) && (col_cur >= COL_BITS'(2));

   always_comb begin
      col_in  = col_ff;
      rows_in = rows_ff;
      if (mode_ff == MODE_EDGE) begin
         col_in = col_wrap ? '0 : col_inc[COL_BITS-1:0];
         if (col_wrap && rows_ff != 2'd2) begin
            rows_in = rows_ff + 2'd1;
         end
      end
      if (req_chan.last_of_block) begin
         col_in  = '0;
         rows_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         rows_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            col_ff  <= col_in;
            rows_ff <= rows_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // hold the transaction for stage 1 while the line store reads its column
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff  <= req_chan.sample;
         s1_last_ff    <= req_chan.last_of_block;
         s1_addr_ff    <= col_cur;
         s1_produce_ff <= (mode_ff == MODE_BAND) || edge_produce;
      end
   end

   // ---------------------------------------------------------------- line store
   logic [2*PIXEL_BITS-1:0] line_rd;
   logic [PIXEL_BITS-1:0]   line_top, line_mid;
   logic                    line_wr_en;

   assign line_wr_en = s1_adv && (mode_ff == MODE_EDGE);

   sao_bef_line_store #(
      .DATA_BITS (2 * PIXEL_BITS),
      .DEPTH     (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept && (mode_ff == MODE_EDGE)),
      .rd_addr (col_cur),
      .wr_en   (line_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data ({line_mid, s1_sample_ff}),
      .rd_data (line_rd)
   );

   assign line_top = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
   assign line_mid = line_rd[PIXEL_BITS-1:0];

   // ---------------------------------------------------------------- stage 1: window
   // entries 0..2: column two to the left (top, middle, bottom); 3..5: one to the left
   logic [PIXEL_BITS-1:0] win_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (line_wr_en) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= line_top;
         win_ff[4] <= line_mid;
         win_ff[5] <= s1_sample_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1: offset
   logic [PIXEL_BITS-1:0] ctr, nb_a, nb_b, base_pix;
   logic [2:0]            cat_idx;
   logic [BAND_BITS-1:0]  band_k;
   offset_sel_type        sel;
   logic signed [OFFSET_BITS-1:0] add_val;
   logic signed [SUM_BITS-1:0]    sum;
   logic [PIXEL_BITS-1:0] clipped;

   assign ctr = win_ff[4];

   always_comb begin
      case (edge_class_ff)
         EDGE_HORIZONTAL: begin nb_a = win_ff[1]; nb_b = line_mid;     end
         EDGE_VERTICAL:   begin nb_a = win_ff[3]; nb_b = win_ff[5];    end
         EDGE_DIAG_45:    begin nb_a = win_ff[0]; nb_b = s1_sample_ff; end
         EDGE_DIAG_135:   begin nb_a = line_top;  nb_b = win_ff[2];    end
         default:         begin nb_a = win_ff[1]; nb_b = line_mid;     end
      endcase
   end

   // 2 + sign(ctr - a) + sign(ctr - b), always in 0..4
   assign cat_idx = 3'd2 + {2'b0, ctr > nb_a} + {2'b0, ctr > nb_b}
                         - {2'b0, ctr < nb_a} - {2'b0, ctr < nb_b};

   assign band_k = s1_sample_ff[PIXEL_BITS-1 -: BAND_BITS] - band_pos_ff;

   always_comb begin
      if (mode_ff == MODE_EDGE) begin
         base_pix = ctr;
         sel      = category_pick(cat_idx);
      end else begin
         base_pix = s1_sample_ff;
         if (band_k < BAND_BITS'(BAND_SPAN)) begin
            case (band_k[1:0])
               2'd0:    sel = OFS_ONE;
               2'd1:    sel = OFS_TWO;
               2'd2:    sel = OFS_THREE;
               default: sel = OFS_FOUR;
            endcase
         end else begin
            sel = OFS_NONE;
         end
      end
   end

   always_comb begin
      case (sel)
         OFS_ONE:   add_val = offset_ff[0];
         OFS_TWO:   add_val = offset_ff[1];
         OFS_THREE: add_val = offset_ff[2];
         OFS_FOUR:  add_val = offset_ff[3];
         default:   add_val = '0;
      endcase
   end

   // clip to pixel range
   assign sum = $signed(SUM_BITS'(base_pix)) + SUM_BITS'(add_val);

   always_comb begin
      if (sum < 0) begin
         clipped = '0;
      end else if (sum > $signed(SUM_BITS'(PIXEL_MAX))) begin
         clipped = PIXEL_BITS'(PIXEL_MAX);
      end else begin
         clipped = sum[PIXEL_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------- output register
   logic [PIXEL_BITS-1:0] rsp_filtered_ff;
   logic                  rsp_eob_ff;
   logic                  rsp_load;

   assign rsp_load = s1_adv && s1_produce_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_filtered_ff <= clipped;
         rsp_eob_ff      <= s1_last_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.filtered     = rsp_filtered_ff;
   assign rsp_chan.end_of_block = rsp_eob_ff;

endmodule

// ===== rtl/sao_bef_checker.sv =====
`timescale 1ns / 1ps

module sao_bef_checker #(
   parameter int PIXEL_BITS = 10
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PIXEL_BITS-1:0] rsp_filtered,
   input logic                  rsp_end_of_block
);

   // a new response must trace back to an accepted request transaction
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response rose without request transaction two cycles before");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_filtered) && $stable(rsp_end_of_block))
      else $error("response payload changed while stalled");

endmodule

bind sao_band_edge_filter sao_bef_checker #(.PIXEL_BITS(PIXEL_BITS)) u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_filtered     (rsp_chan.filtered),
   .rsp_end_of_block (rsp_chan.end_of_block)
);
